FILE: design/smpq_pkg.sv
// Shared types and constants for the sorted min-priority queue.
`default_nettype none

package smpq_pkg;

  localparam int unsigned PrioWidth  = 16;
  localparam int unsigned CountWidth = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [PrioWidth-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [PrioWidth-1:0]  removed_value;
    logic [CountWidth-1:0] entry_count;
    logic [PrioWidth-1:0]  smallest_value;
    logic                  is_empty;
    logic                  underflow;
    logic                  overflow;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic insert;
    logic remove;
    logic underflow;
    logic overflow;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } status_t;

endpackage

`default_nettype wire

FILE: design/smpq_ctrl.sv
// Handshake controller: accepts transactions, issues datapath commands, holds result valid.
`default_nettype none

module smpq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             op_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire smpq_pkg::status_t status_i,
  output smpq_pkg::cmd_t        cmd_o
);
  import smpq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_q;
  logic state_d;
  logic accept;

  assign out_valid_o = (state_q == ST_HOLD);
  assign in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.capture   = accept;
    cmd_o.insert    = accept && (op_i == OP_INSERT) && !status_i.full;
    cmd_o.overflow  = accept && (op_i == OP_INSERT) && status_i.full;
    cmd_o.remove    = accept && (op_i == OP_REMOVE) && !status_i.empty;
    cmd_o.underflow = accept && (op_i == OP_REMOVE) && status_i.empty;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) begin
          state_d = ST_HOLD;
        end else if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_single_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.insert, cmd_o.remove, cmd_o.underflow, cmd_o.overflow}) <= 1)
    else $error("more than one datapath action in a cycle");

  a_action_needs_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.insert || cmd_o.remove || cmd_o.underflow || cmd_o.overflow) |-> cmd_o.capture)
    else $error("datapath action without capture");

  a_capture_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_o)
    else $error("captured result not presented");

endmodule

`default_nettype wire

FILE: design/smpq_datapath.sv
// Sorted entry cells, entry count and result register.
`default_nettype none

module smpq_datapath #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire smpq_pkg::cmd_t cmd_i,
  input  wire smpq_pkg::req_t req_i,
  output smpq_pkg::status_t   status_o,
  output smpq_pkg::rsp_t      rsp_o
);
  import smpq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [VALUE_WIDTH-1:0] entry_q [CAPACITY];
  logic [VALUE_WIDTH-1:0] entry_d [CAPACITY];
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        count_d;
  logic [CAPACITY-1:0]    ge;
  logic [31:0]            pri_ext;
  logic [VALUE_WIDTH-1:0] pri;
  logic [VALUE_WIDTH-1:0] removed;
  logic [VALUE_WIDTH-1:0] smallest;
  logic [31:0]            removed_ext;
  logic [31:0]            smallest_ext;
  logic [31:0]            count_ext;
  rsp_t                   rsp_q;

  assign pri_ext = 32'(req_i.priority_req);
  assign pri     = pri_ext[VALUE_WIDTH-1:0];

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(CAPACITY));

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      ge[k] = (CntW'(k) >= count_q) || (entry_q[k] >= pri);
    end
  end

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      entry_d[k] = entry_q[k];
      if (cmd_i.insert) begin
        if (ge[k]) begin
          if (k == 0) begin
            entry_d[k] = pri;
          end else begin
            entry_d[k] = ge[k-1] ? entry_q[k-1] : pri;
          end
        end
      end else if (cmd_i.remove) begin
        if (k < CAPACITY - 1) entry_d[k] = entry_q[k+1];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    removed  = '0;
    smallest = status_o.empty ? '0 : entry_q[0];
    if (cmd_i.insert) begin
      count_d  = count_q + CntW'(1);
      smallest = ge[0] ? pri : entry_q[0];
    end else if (cmd_i.remove) begin
      count_d  = count_q - CntW'(1);
      removed  = entry_q[0];
      smallest = (count_q > CntW'(1)) ? entry_q[1] : '0;
    end
  end

  assign removed_ext  = 32'(removed);
  assign smallest_ext = 32'(smallest);
  assign count_ext    = 32'(count_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert || cmd_i.remove) begin
      entry_q <= entry_d;
    end
    if (cmd_i.capture) begin
      rsp_q.removed_value  <= removed_ext[PrioWidth-1:0];
      rsp_q.entry_count    <= count_ext[CountWidth-1:0];
      rsp_q.smallest_value <= smallest_ext[PrioWidth-1:0];
      rsp_q.is_empty       <= (count_d == '0);
      rsp_q.underflow      <= cmd_i.underflow;
      rsp_q.overflow       <= cmd_i.overflow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign rsp_o = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not advance count");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.remove |=> count_q == $past(count_q) - CntW'(1))
    else $error("remove did not drop count");

  a_head_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (entry_q[0] <= entry_q[1]))
    else $error("head entries out of order");

endmodule

`default_nettype wire

FILE: design/sorted_min_priority_queue_unit.sv
// Sorted min-priority queue top level: controller plus compare-and-shift datapath.
// Each transaction is an insert or a remove of the smallest entry and returns one result.
// In every transaction all CAPACITY cells compare against the new priority and shift
// in parallel at the accepting edge, and the result is registered and shown the
// next cycle. in_ready_o is high while the result register is empty or being taken, so one
// transaction per cycle is sustained when the output side keeps out_ready_i high.
// No clearing pass follows reset; the queue is empty at once.
`default_nettype none

module sorted_min_priority_queue_unit #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire smpq_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output smpq_pkg::rsp_t      out_rsp_o
);
  import smpq_pkg::*;

  cmd_t    cmd;
  status_t status;

  smpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (in_req_i.operation),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smpq_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (in_req_i),
    .status_o(status),
    .rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire
